// File: sv/adam_pkg.sv
// Constants, types and helper functions for the Adam weight update block.
`default_nettype none

package adam_pkg;

  localparam int IDX_W        = 10;
  localparam int ELEMENTS_DEF = 1024;
  localparam int CFG_IDX_W    = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DECAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO   = 3'd4;

  // Register reset values
  localparam logic [31:0] BASE_RATE_RST  = 32'd4294967;
  localparam logic [31:0] RATE_DECAY_RST = 32'd0;
  localparam logic [31:0] EPSILON_RST    = 32'd429;
  localparam logic [23:0] BETA_ONE_RST   = 24'd7549747;
  localparam logic [23:0] BETA_TWO_RST   = 24'd8380219;

  localparam logic [23:0] ONE_Q23 = 24'h80_0000;
  localparam logic [47:0] V_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;

  // Pipeline segment lengths (one quotient or root bit per stage)
  localparam int M_DIV_BITS = 32;
  localparam int V_DIV_BITS = 48;
  localparam int ROOT_BITS  = 32;
  localparam int Q_BITS     = 34;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_MUL,
    RS_DIV
  } rate_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic [31:0]        rate;
  } tag_t;

  // Bias correction division stage word
  typedef struct packed {
    tag_t        tag;
    logic        mneg;
    logic        movf;
    logic [31:0] mq;
    logic [23:0] mrem;
    logic [31:0] mlow;
    logic [23:0] c1;
    logic        vovf;
    logic [47:0] vq;
    logic [23:0] vrem;
    logic [47:0] vlow;
    logic [23:0] c2;
  } dv_t;

  // Square root stage word
  typedef struct packed {
    tag_t        tag;
    logic        mneg;
    logic        sat;
    logic [31:0] mh;
    logic [31:0] root;
    logic [33:0] rem;
    logic [63:0] x;
  } sq_t;

  // Numerator and denominator of the step division
  typedef struct packed {
    tag_t        tag;
    logic        mneg;
    logic        sat;
    logic [63:0] num;
    logic [40:0] den;
  } fm_t;

  // Step division stage word
  typedef struct packed {
    tag_t        tag;
    logic        mneg;
    logic        sat;
    logic        ovf;
    logic [33:0] q;
    logic [40:0] rem;
    logic [33:0] low;
    logic [40:0] den;
  } fd_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [IDX_W-1:0]   idx;
    logic               sat;
  } out_t;

  function automatic logic [23:0] clamp_beta(input logic [23:0] b);
    return (b > ONE_Q23) ? ONE_Q23 : b;
  endfunction

  // Correction divisor 1 - power; a power of one leaves the moment uncorrected
  function automatic logic [23:0] corr_div(input logic [23:0] p);
    logic [23:0] c;
    c = ONE_Q23 - p;
    return (c == 24'd0) ? ONE_Q23 : c;
  endfunction

  // One restoring division step on a 24-bit divisor: {quotient bit, remainder}
  function automatic logic [24:0] dstep24(input logic [23:0] rem, input logic nb,
                                          input logic [23:0] d);
    logic [24:0] t;
    logic        ge;
    t  = {rem, nb};
    ge = (t >= {1'b0, d});
    return {ge, ge ? 24'(t - {1'b0, d}) : t[23:0]};
  endfunction

endpackage

`default_nettype wire

// File: sv/adam_update.sv
// Adam optimizer weight update: moment stores, bias correction and saturating step.
//
// Usage: configuration registers are written through cfg_write/cfg_index/cfg_data
// while the block is idle. Input words (element_index, gradient, weight_in,
// step_last) are taken on in_valid && in_ready; one result word (weight_out,
// index_out, saturated) per input leaves on out_valid && out_ready, in order.
// Throughput is one word per cycle within a step while the receiver keeps up; the
// pipeline is set by a 48-stage bias correction divider (first moment divider in
// parallel), a 32-stage square root and a 34-stage step divider. After a word with
// step_last set and a nonzero rate_decay, the learning rate is recomputed by an
// iterative 32-bit divider while in_ready stays low. Moment stores are read and
// written back in one stage with a forward path, so repeated indexes stream
// without gaps.
// After reset the moment stores are cleared one entry per cycle (ELEMENTS entries,
// 1024 by default) with in_ready low; configuration writes are taken.
// When the receiver stalls, the result drops into a skid register and the
// pipeline freezes only once that register is full; nothing is lost or repeated.
`default_nettype none

module adam_update import adam_pkg::*; #(
  parameter int ELEMENTS = ELEMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     element_index,
  input  logic signed [31:0]   gradient,
  input  logic signed [31:0]   weight_in,
  input  logic                 step_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   weight_out,
  output logic [IDX_W-1:0]     index_out,
  output logic                 saturated
);

  localparam int SLOT_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int RED_W  = IDX_W + 18;
  localparam int DV_N   = V_DIV_BITS;
  localparam int SQ_N   = ROOT_BITS;
  localparam int FD_N   = Q_BITS;

  // Configuration and step state
  logic [31:0] base_rate, rate_decay, epsilon, cur_rate, step_count;
  logic [23:0] beta_one, beta_two, bp1, bp2;
  logic [23:0] b1c, b2c, ob1, ob2;

  // Rate sequencer
  rate_state_t rs, rs_next;
  logic        rate_busy, rate_load, rate_done;
  logic [4:0]  rcnt;
  logic [64:0] rdiv_d, rrem;
  logic [31:0] rq, rq_next;
  logic [65:0] rtrial;
  logic        rge;

  // Clearing pass
  logic              clearing;
  logic [SLOT_W-1:0] clr_cnt;

  // Flow control
  logic adv, in_acc, out_take;

  // Front stages
  logic               s1_valid, s2_valid, s3_valid;
  tag_t               s1_tag, s2_tag, s3_tag;
  logic signed [31:0] s1_g, s2_g, s3_m;
  logic [23:0]        s1_c1, s1_c2, s2_c1, s2_c2, s3_c1, s3_c2;
  logic [47:0]        s2_g2, s3_v;
  logic [SLOT_W-1:0]  s1_slot, s2_slot;
  logic [RED_W-1:0]   red;
  logic [31:0]        s1_ag;

  // Moment stores
  logic signed [31:0] mem_m [ELEMENTS];
  logic [47:0]        mem_v [ELEMENTS];
  logic signed [31:0] rd_m, mold, mem_wm;
  logic [47:0]        rd_v, vold, mem_wv;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  logic               lw_valid;
  logic [SLOT_W-1:0]  lw_slot;
  logic signed [31:0] lw_m;
  logic [47:0]        lw_v;

  // Moment update arithmetic
  logic signed [57:0] mb1, mob1, mold58, g58, msum;
  logic signed [31:0] m_new;
  logic [47:0]        vhi, vlo, ghi, glo, v_new;
  logic [49:0]        vsum;

  // Deep segments
  logic dv_v [DV_N+1];
  dv_t  dvp  [DV_N+1];
  dv_t  dvn  [DV_N];
  dv_t  dv_init;
  logic [31:0] s3_am;

  logic sq_v [SQ_N+1];
  sq_t  sqp  [SQ_N+1];
  sq_t  sqn  [SQ_N];
  sq_t  sq_init;

  logic fm_v;
  fm_t  fmp, fm_d;

  logic fd_v [FD_N+1];
  fd_t  fdp  [FD_N+1];
  fd_t  fdn  [FD_N];
  fd_t  fd_init;

  // Output side
  out_t fin, out_d, skid_d;
  logic fin_valid, skid_valid;

  assign b1c = clamp_beta(beta_one);
  assign b2c = clamp_beta(beta_two);
  assign ob1 = ONE_Q23 - b1c;
  assign ob2 = ONE_Q23 - b2c;

  assign adv      = !skid_valid;
  assign in_ready = adv && !clearing && !rate_busy;
  assign in_acc   = in_valid && in_ready;
  assign out_take = out_ready || !out_valid;

  // Configuration registers and per-step state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_rate  <= BASE_RATE_RST;
      rate_decay <= RATE_DECAY_RST;
      epsilon    <= EPSILON_RST;
      beta_one   <= BETA_ONE_RST;
      beta_two   <= BETA_TWO_RST;
      bp1        <= clamp_beta(BETA_ONE_RST);
      bp2        <= clamp_beta(BETA_TWO_RST);
      cur_rate   <= BASE_RATE_RST;
      step_count <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BASE_RATE: begin
            base_rate <= cfg_data;
            cur_rate  <= cfg_data;
          end
          REG_RATE_DECAY: rate_decay <= cfg_data;
          REG_EPSILON:    epsilon    <= cfg_data;
          REG_BETA_ONE: begin
            beta_one <= cfg_data[23:0];
            bp1      <= clamp_beta(cfg_data[23:0]);
          end
          REG_BETA_TWO: begin
            beta_two <= cfg_data[23:0];
            bp2      <= clamp_beta(cfg_data[23:0]);
          end
          default: ;
        endcase
      end
      if (in_acc && step_last) begin
        step_count <= step_count + 32'd1;
        bp1 <= 24'((48'(bp1) * 48'(b1c)) >> 23);
        bp2 <= 24'((48'(bp2) * 48'(b2c)) >> 23);
      end
      if (rate_done) cur_rate <= rq_next;
    end
  end

  // Rate sequencer: next state
  always_comb begin
    rs_next = rs;
    unique case (rs)
      RS_IDLE: if (in_acc && step_last && rate_decay != 32'd0) rs_next = RS_MUL;
      RS_MUL:  rs_next = RS_DIV;
      RS_DIV:  if (rcnt == 5'd0) rs_next = RS_IDLE;
      default: rs_next = RS_IDLE;
    endcase
  end

  // Rate sequencer: outputs
  always_comb begin
    rate_busy = 1'b0;
    rate_load = 1'b0;
    rate_done = 1'b0;
    unique case (rs)
      RS_IDLE: ;
      RS_MUL: begin
        rate_busy = 1'b1;
        rate_load = 1'b1;
      end
      RS_DIV: begin
        rate_busy = 1'b1;
        rate_done = (rcnt == 5'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) rs <= RS_IDLE;
    else     rs <= rs_next;
  end

  // One bit of base_rate * 2^32 / (2^32 + decay * step) per cycle
  assign rtrial  = {rrem, 1'b0};
  assign rge     = (rtrial >= {1'b0, rdiv_d});
  assign rq_next = {rq[30:0], rge};

  always_ff @(posedge clk) begin
    if (rate_load) begin
      rdiv_d <= 65'(64'(rate_decay) * 64'(step_count)) + 65'h1_0000_0000;
      rrem   <= 65'(base_rate);
      rq     <= '0;
      rcnt   <= 5'd31;
    end else if (rs == RS_DIV) begin
      rrem <= rge ? 65'(rtrial - {1'b0, rdiv_d}) : 65'(rtrial);
      rq   <= rq_next;
      rcnt <= rcnt - 5'd1;
    end
  end

  // Clear the moment stores after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == SLOT_W'(ELEMENTS - 1)) clearing <= 1'b0;
      else clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      fm_v     <= 1'b0;
      for (int i = 0; i <= DV_N; i++) dv_v[i] <= 1'b0;
      for (int i = 0; i <= SQ_N; i++) sq_v[i] <= 1'b0;
      for (int i = 0; i <= FD_N; i++) fd_v[i] <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_acc;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      dv_v[0]  <= s3_valid;
      for (int i = 0; i < DV_N; i++) dv_v[i+1] <= dv_v[i];
      sq_v[0]  <= dv_v[DV_N];
      for (int i = 0; i < SQ_N; i++) sq_v[i+1] <= sq_v[i];
      fm_v     <= sq_v[SQ_N];
      fd_v[0]  <= fm_v;
      for (int i = 0; i < FD_N; i++) fd_v[i+1] <= fd_v[i];
    end
  end

  // Reduce the index to a store slot
  always_comb begin
    red = RED_W'(s1_tag.idx);
    for (int j = IDX_W - 1; j >= 0; j--) begin
      if (red >= (RED_W'(ELEMENTS) << j)) red = red - (RED_W'(ELEMENTS) << j);
    end
    s1_slot = red[SLOT_W-1:0];
    s1_ag   = s1_g[31] ? 32'(-s1_g) : 32'(s1_g);
  end

  // Advance the front stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= '{idx: element_index, w: weight_in, rate: cur_rate};
      s1_g   <= gradient;
      s1_c1  <= corr_div(bp1);
      s1_c2  <= corr_div(bp2);
      s2_tag  <= s1_tag;
      s2_g    <= s1_g;
      s2_g2   <= 48'((64'(s1_ag) * 64'(s1_ag)) >> 16);
      s2_slot <= s1_slot;
      s2_c1   <= s1_c1;
      s2_c2   <= s1_c2;
      s3_tag <= s2_tag;
      s3_m   <= m_new;
      s3_v   <= v_new;
      s3_c1  <= s2_c1;
      s3_c2  <= s2_c2;
    end
  end

  // Forward the most recent write over the store read
  assign mold = (lw_valid && lw_slot == s2_slot) ? lw_m : rd_m;
  assign vold = (lw_valid && lw_slot == s2_slot) ? lw_v : rd_v;

  // Mix the moments
  always_comb begin
    mb1    = 58'(signed'({1'b0, b1c}));
    mob1   = 58'(signed'({1'b0, ob1}));
    mold58 = 58'(mold);
    g58    = 58'(s2_g);
    msum   = mb1 * mold58 + mob1 * g58;
    m_new  = msum[54:23];
    vhi    = 48'(vold[47:24]) * 48'(b2c);
    vlo    = 48'(vold[23:0]) * 48'(b2c);
    ghi    = 48'(s2_g2[47:24]) * 48'(ob2);
    glo    = 48'(s2_g2[23:0]) * 48'(ob2);
    vsum   = 50'({vhi, 1'b0}) + 50'(vlo[47:23]) + 50'({ghi, 1'b0}) + 50'(glo[47:23]);
    v_new  = (vsum > 50'(V_MAX)) ? V_MAX : vsum[47:0];
  end

  assign mem_we = clearing || (s2_valid && adv);
  assign mem_wa = clearing ? clr_cnt : s2_slot;
  assign mem_wm = clearing ? 32'sd0 : m_new;
  assign mem_wv = clearing ? 48'd0 : v_new;

  // Moment stores: write back, read the next slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_m[mem_wa] <= mem_wm;
      mem_v[mem_wa] <= mem_wv;
    end
    if (adv) begin
      rd_m <= mem_m[s1_slot];
      rd_v <= mem_v[s1_slot];
    end
  end

  // Hold the last written entry for forwarding
  always_ff @(posedge clk) begin
    if (rst) lw_valid <= 1'b0;
    else if (s2_valid && adv && !clearing) lw_valid <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (s2_valid && adv && !clearing) begin
      lw_slot <= s2_slot;
      lw_m    <= m_new;
      lw_v    <= v_new;
    end
  end

  // Set up both correction divisions
  always_comb begin
    s3_am = s3_m[31] ? 32'(-s3_m) : 32'(s3_m);
    dv_init.tag  = s3_tag;
    dv_init.mneg = s3_m[31];
    dv_init.mrem = 24'(s3_am[31:9]);
    dv_init.mlow = {s3_am[8:0], 23'd0};
    dv_init.movf = (24'(s3_am[31:9]) >= s3_c1);
    dv_init.mq   = '0;
    dv_init.c1   = s3_c1;
    dv_init.vrem = 24'(s3_v[47:25]);
    dv_init.vlow = {s3_v[24:0], 23'd0};
    dv_init.vovf = (24'(s3_v[47:25]) >= s3_c2);
    dv_init.vq   = '0;
    dv_init.c2   = s3_c2;
  end

  // One quotient bit per stage; the first moment finishes early and rides along
  always_comb begin
    logic [24:0] ms, vs;
    for (int i = 0; i < DV_N; i++) begin
      dvn[i] = dvp[i];
      ms = dstep24(dvp[i].mrem, dvp[i].mlow[31], dvp[i].c1);
      vs = dstep24(dvp[i].vrem, dvp[i].vlow[47], dvp[i].c2);
      if (i < M_DIV_BITS) begin
        dvn[i].mrem = ms[23:0];
        dvn[i].mq   = {dvp[i].mq[30:0], ms[24]};
        dvn[i].mlow = {dvp[i].mlow[30:0], 1'b0};
      end
      dvn[i].vrem = vs[23:0];
      dvn[i].vq   = {dvp[i].vq[46:0], vs[24]};
      dvn[i].vlow = {dvp[i].vlow[46:0], 1'b0};
    end
  end

  // Clamp mhat and vhat, start the root
  always_comb begin
    logic [31:0] mlim;
    logic        mclamp;
    logic [47:0] vh;
    mlim   = dvp[DV_N].mneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mclamp = dvp[DV_N].movf || (dvp[DV_N].mq > mlim);
    vh     = dvp[DV_N].vovf ? V_MAX : dvp[DV_N].vq;
    sq_init.tag  = dvp[DV_N].tag;
    sq_init.mneg = dvp[DV_N].mneg;
    sq_init.sat  = mclamp || dvp[DV_N].vovf;
    sq_init.mh   = mclamp ? mlim : dvp[DV_N].mq;
    sq_init.root = '0;
    sq_init.rem  = '0;
    sq_init.x    = {vh, 16'd0};
  end

  // One root bit per stage
  always_comb begin
    logic [35:0] t, trial;
    logic        ge;
    for (int i = 0; i < SQ_N; i++) begin
      sqn[i] = sqp[i];
      t      = {sqp[i].rem, sqp[i].x[63:62]};
      trial  = 36'({sqp[i].root, 2'b01});
      ge     = (t >= trial);
      sqn[i].rem  = ge ? 34'(t - trial) : 34'(t);
      sqn[i].root = {sqp[i].root[30:0], ge};
      sqn[i].x    = {sqp[i].x[61:0], 2'b00};
    end
  end

  // Form the step numerator and denominator
  always_comb begin
    logic [40:0] den;
    den = 41'({sqp[SQ_N].root, 8'd0}) + 41'(epsilon);
    fm_d.tag  = sqp[SQ_N].tag;
    fm_d.mneg = sqp[SQ_N].mneg;
    fm_d.sat  = sqp[SQ_N].sat;
    fm_d.num  = 64'(sqp[SQ_N].tag.rate) * 64'(sqp[SQ_N].mh);
    fm_d.den  = (den == 41'd0) ? 41'd1 : den;
  end

  // Set up the step division
  always_comb begin
    fd_init.tag  = fmp.tag;
    fd_init.mneg = fmp.mneg;
    fd_init.sat  = fmp.sat;
    fd_init.ovf  = (41'(fmp.num[63:34]) >= fmp.den);
    fd_init.q    = '0;
    fd_init.rem  = 41'(fmp.num[63:34]);
    fd_init.low  = fmp.num[33:0];
    fd_init.den  = fmp.den;
  end

  // One step quotient bit per stage
  always_comb begin
    logic [41:0] t;
    logic        ge;
    for (int i = 0; i < FD_N; i++) begin
      fdn[i] = fdp[i];
      t      = {fdp[i].rem, fdp[i].low[33]};
      ge     = (t >= {1'b0, fdp[i].den});
      fdn[i].rem = ge ? 41'(t - {1'b0, fdp[i].den}) : 41'(t);
      fdn[i].q   = {fdp[i].q[32:0], ge};
      fdn[i].low = {fdp[i].low[32:0], 1'b0};
    end
  end

  // Advance the deep segments
  always_ff @(posedge clk) begin
    if (adv) begin
      dvp[0] <= dv_init;
      for (int i = 0; i < DV_N; i++) dvp[i+1] <= dvn[i];
      sqp[0] <= sq_init;
      for (int i = 0; i < SQ_N; i++) sqp[i+1] <= sqn[i];
      fmp    <= fm_d;
      fdp[0] <= fd_init;
      for (int i = 0; i < FD_N; i++) fdp[i+1] <= fdn[i];
    end
  end

  // Apply the step and saturate the weight
  always_comb begin
    logic [33:0]        qf;
    logic signed [34:0] nw;
    logic               wsat;
    qf = (fdp[FD_N].ovf || fdp[FD_N].q > STEP_CAP) ? STEP_CAP : fdp[FD_N].q;
    if (fdp[FD_N].mneg) nw = 35'(fdp[FD_N].tag.w) + signed'({1'b0, qf});
    else                nw = 35'(fdp[FD_N].tag.w) - signed'({1'b0, qf});
    wsat = 1'b1;
    if (nw > 35'sd2147483647)       fin.weight = 32'sh7FFF_FFFF;
    else if (nw < -35'sd2147483648) fin.weight = 32'sh8000_0000;
    else begin
      fin.weight = nw[31:0];
      wsat       = 1'b0;
    end
    fin.idx = fdp[FD_N].tag.idx;
    fin.sat = fdp[FD_N].sat || wsat;
  end

  assign fin_valid = fd_v[FD_N];

  // Output register with a skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (out_take) out_valid  <= 1'b1;
      else          skid_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_d <= skid_d;
    end else if (fin_valid) begin
      if (out_take) out_d  <= fin;
      else          skid_d <= fin;
    end
  end

  assign weight_out = out_d.weight;
  assign index_out  = out_d.idx;
  assign saturated  = out_d.sat;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the Adam weight update block: directed rows, then random phases.
`default_nettype none

module tb_top;
  import adam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS    = 1024;
  localparam int LATENCY   = 130;
  localparam int WATCHDOG  = 6000;
  localparam int PHASE_ITEMS = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [31:0]      grad;
    logic [31:0]      w;
    logic             last;
    logic             known;
    logic [31:0]      exp_w;
    logic             exp_sat;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [IDX_W-1:0]     element_index = '0;
  logic signed [31:0]   gradient = '0;
  logic signed [31:0]   weight_in = '0;
  logic                 step_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   weight_out;
  logic [IDX_W-1:0]     index_out;
  logic                 saturated;

  // Mirror of the block's state and registers
  logic [31:0]        rate_base, rate_decay, eps_reg, rate_now, steps;
  logic [23:0]        b1_reg, b2_reg, b1_pow, b2_pow;
  logic signed [31:0] mom1 [NSLOTS];
  logic [47:0]        mom2 [NSLOTS];

  out_t       pending_weights[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         errors = 0;
  int         quiet_cycles = 0;

  adam_update DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [23:0] beta_sat(logic [23:0] b);
    return (b > ONE_Q23) ? ONE_Q23 : b;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] arg);
    logic [64:0] x, res, bv;
    x = {1'b0, arg};
    res = '0;
    bv = 65'd1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res[63:0];
  endfunction

  // Apply one register write to the mirrored state
  function automatic void mirror_write(logic [CFG_IDX_W-1:0] ri, logic [31:0] d);
    case (ri)
      REG_BASE_RATE: begin
        rate_base = d;
        rate_now = d;
      end
      REG_RATE_DECAY: rate_decay = d;
      REG_EPSILON: eps_reg = d;
      REG_BETA_ONE: begin
        b1_reg = d[23:0];
        b1_pow = beta_sat(d[23:0]);
      end
      REG_BETA_TWO: begin
        b2_reg = d[23:0];
        b2_pow = beta_sat(d[23:0]);
      end
      default: ;
    endcase
  endfunction

  // Compute the updated weight for one word and advance the mirrored state
  function automatic out_t adam_predict(logic [IDX_W-1:0] idx, logic [31:0] g_in,
                                        logic [31:0] w_in, logic last);
    out_t        r;
    int          slot;
    longint      g, w, m, nw, sum;
    logic [23:0] b1, b2;
    logic [63:0] ag, g2, am, mh, mlim, c1, c2, q0, rem, vh, root, den, q, p, dv;
    logic [95:0] t1, t2;
    logic [63:0] v;
    logic        sat, mneg;
    slot = idx % NSLOTS;
    g = longint'(signed'(g_in));
    w = longint'(signed'(w_in));
    b1 = beta_sat(b1_reg);
    b2 = beta_sat(b2_reg);
    sat = 1'b0;

    // First moment, floored mix
    sum = longint'(b1) * longint'(mom1[slot]) + longint'(ONE_Q23 - b1) * g;
    m = sum >>> 23;
    mom1[slot] = m[31:0];

    // Second moment
    ag = (g < 0) ? -g : g;
    g2 = (ag * ag) >> 16;
    t1 = (96'(mom2[slot]) * 96'(b2)) >> 23;
    t2 = (96'(g2) * 96'(ONE_Q23 - b2)) >> 23;
    v = t1[63:0] + t2[63:0];
    if (v > 64'(V_MAX)) v = 64'(V_MAX);
    mom2[slot] = v[47:0];

    // Bias correction; a power of one leaves the moment as is
    c1 = 64'(ONE_Q23 - b1_pow);
    c2 = 64'(ONE_Q23 - b2_pow);
    if (c1 == 0) c1 = 64'(ONE_Q23);
    if (c2 == 0) c2 = 64'(ONE_Q23);
    mneg = m < 0;
    am = mneg ? -m : m;
    mh = (am << 23) / c1;
    mlim = mneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mh > mlim) begin
      mh = mlim;
      sat = 1'b1;
    end
    q0 = v / c2;
    rem = v % c2;
    if (q0 >= (64'd1 << 25)) begin
      vh = 64'(V_MAX);
      sat = 1'b1;
    end else begin
      vh = (q0 << 23) + ((rem << 23) / c2);
      if (vh > 64'(V_MAX)) begin
        vh = 64'(V_MAX);
        sat = 1'b1;
      end
    end

    // Step size; a zero denominator becomes one LSB
    root = int_root(vh << 16);
    den = (root << 8) + 64'(eps_reg);
    if (den == 0) den = 64'd1;
    q = (64'(rate_now) * mh) / den;
    if (q > (64'd1 << 33)) q = 64'd1 << 33;
    nw = mneg ? w + longint'(q) : w - longint'(q);
    if (nw > 64'sd2147483647) begin
      nw = 64'sd2147483647;
      sat = 1'b1;
    end
    if (nw < -64'sd2147483648) begin
      nw = -64'sd2147483648;
      sat = 1'b1;
    end
    r.weight = nw[31:0];
    r.idx = idx;
    r.sat = sat;

    // Advance step count, powers and rate after the closing word
    if (last) begin
      steps = steps + 32'd1;
      b1_pow = 24'((64'(b1_pow) * 64'(b1)) >> 23);
      b2_pow = 24'((64'(b2_pow) * 64'(b2)) >> 23);
      if (rate_decay != 0) begin
        p = 64'(rate_decay) * 64'(steps);
        dv = (p > 64'hFFFF_FFFE_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : p + 64'h1_0000_0000;
        rate_now = 32'((64'(rate_base) << 32) / dv);
      end
    end
    return r;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Write all five registers back to back, then drop the enable
  task automatic load_config(logic [31:0] br, logic [31:0] dc, logic [31:0] ep,
                             logic [31:0] b1, logic [31:0] b2);
    logic [31:0] vals [5];
    vals = '{br, dc, ep, b1, b2};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      mirror_write(CFG_IDX_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Offer one word, hold it until taken, then queue its expected result
  task automatic send_word(logic [IDX_W-1:0] idx, logic [31:0] g, logic [31:0] w,
                           logic last, logic known, logic [31:0] kw, logic ks);
    out_t exp_r;
    int   pct;
    pct = 0;
    if (idle_mode == IDLE_SEND) pct = 65;
    else if (idle_mode == IDLE_BOTH) pct = 29;
    // Idle the sender cycle by cycle before offering the word
    while (roll(pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    element_index <= idx;
    gradient <= g;
    weight_in <= w;
    step_last <= last;
    do @(posedge clk); while (!in_ready);
    exp_r = adam_predict(idx, g, w, last);
    if (known) begin
      exp_r.weight = kw;
      exp_r.sat = ks;
    end
    pending_weights.push_back(exp_r);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_weights.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(255);
      3: return 32'(-int'($urandom_range(4096)));
      default: return $urandom();
    endcase
  endfunction

  // Check each result word against the oldest expectation; watch for hangs
  always @(posedge clk) begin
    out_t e;
    if (!rst) begin
      if ((idle_mode == IDLE_RECV && roll(65)) || (idle_mode == IDLE_BOTH && roll(29)))
        out_ready <= 1'b0;
      else
        out_ready <= 1'b1;
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("adam_update: mismatch");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_weights.size() == 0) begin
          $error("result word with nothing expected: weight_out %h", weight_out);
          errors++;
        end else begin
          e = pending_weights.pop_front();
          if (weight_out !== e.weight) begin
            $error("weight_out expected %h actual %h", e.weight, weight_out);
            errors++;
          end
          if (index_out !== e.idx) begin
            $error("index_out expected %0d actual %0d", e.idx, index_out);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %0b actual %0b", e.sat, saturated);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    logic [IDX_W-1:0] pool [8];
    logic [IDX_W-1:0] idx;
    logic [31:0] br, dc, ep, b1, b2;

    rate_base = BASE_RATE_RST;
    rate_decay = RATE_DECAY_RST;
    eps_reg = EPSILON_RST;
    b1_reg = BETA_ONE_RST;
    b2_reg = BETA_TWO_RST;
    b1_pow = BETA_ONE_RST;
    b2_pow = BETA_TWO_RST;
    rate_now = BASE_RATE_RST;
    steps = '0;
    foreach (mom1[i]) mom1[i] = '0;
    foreach (mom2[i]) mom2[i] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: reset-state moments, field extremes, zero denominator
    rows = '{
      '{10'd0,    32'h0,        32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
      '{10'd1023, 32'h0,        32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{10'd5,    32'h0,        32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
      '{10'd9,    32'h0,        32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678, 1'b0},
      '{10'd7,    32'd200,      32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
      '{10'd0,    32'h7FFF_FFFF, 32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
      '{10'd1,    32'h8000_0000, 32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
      '{10'd2,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{10'd3,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{10'd0,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
      '{10'd0,    -32'sd12345,  32'd100,      1'b1, 1'b0, 32'h0, 1'b0},
      '{10'd1023, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0, 1'b0},
      '{10'd512,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0, 1'b0}
    };
    load_config(BASE_RATE_RST, RATE_DECAY_RST, 32'd0, BETA_ONE_RST, BETA_TWO_RST);
    foreach (rows[i])
      send_word(rows[i].idx, rows[i].grad, rows[i].w, rows[i].last,
                rows[i].known, rows[i].exp_w, rows[i].exp_sat);
    drain();

    // Random phases across register settings and idling patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin  // max rate, beta one at exactly one, beta two zero
          br = 32'hFFFF_FFFF; dc = 0; ep = 0; b1 = ONE_Q23; b2 = 0;
        end
        1: begin  // betas above one, maximum decay and epsilon
          br = $urandom(); dc = 32'hFFFF_FFFF; ep = 32'hFFFF_FFFF;
          b1 = 32'hFF_FFFF; b2 = 32'h80_0009;
        end
        2: begin
          br = 0; dc = 1; ep = $urandom(); b1 = 0; b2 = $urandom_range(8388608);
        end
        3: begin
          br = BASE_RATE_RST; dc = $urandom(); ep = EPSILON_RST;
          b1 = BETA_ONE_RST; b2 = BETA_TWO_RST;
        end
        default: begin
          br = $urandom(); dc = $urandom_range(1000); ep = $urandom_range(1000000);
          b1 = $urandom_range(8388608); b2 = $urandom_range(8388608);
        end
      endcase
      idle_mode = idle_mode_t'(ph % 4);
      load_config(br, dc, ep, b1, b2);
      foreach (pool[i]) pool[i] = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly revisit a small set of slots so moments build up
        idx = roll(70) ? pool[$urandom_range(7)] : IDX_W'($urandom());
        send_word(idx, pick_value(), pick_value(), roll(8), 1'b0, '0, 1'b0);
        if (n == PHASE_ITEMS / 2 && idle_mode == IDLE_NONE) idle_mode = IDLE_BOTH;
      end
      drain();
    end

    if (errors == 0) begin
      $display("adam_update: match");
    end else begin
      $display("adam_update: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/adam_pkg.sv
sv/adam_update.sv
dv/tb_top.sv
